>>> hw/rtl/cdq_pkg.sv
package cdq_pkg;

  // ring size and derived widths
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

  // action codes
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [DW-1:0] NO_DATA = '1;

  typedef struct packed {
    logic [1:0]           action;
    logic signed [DW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] data;
    logic [1:0]           status;
    logic                 empty_flag;
    logic                 full_flag;
  } rsp_t;

  function automatic logic [AW-1:0] ring_up(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_down(input logic [AW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - AW'(1);
  endfunction

endpackage

>>> hw/rtl/cdq_ram.sv
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/circular_deque.sv
// response path: an accepted request waits in the single pending slot for the
//   registered ram read, then moves to the response register; no new request
//   is taken while that slot is full or the response register is stalled
// reset: pointers and count clear at once, the deque starts empty, no
//   clearing pass; the ring contents stay undefined until written
module circular_deque (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cdq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cdq_pkg::rsp_t rsp_o
);

  // end pointers and word count
  logic [cdq_pkg::AW-1:0] front_q, front_d;
  logic [cdq_pkg::AW-1:0] rear_q, rear_d;
  logic [cdq_pkg::CW-1:0] count_q, count_d;

  // one request in flight, waiting on the ram read
  logic                   pend_q;
  logic                   pend_pop_q;
  logic [1:0]             pend_status_q;
  logic                   pend_empty_q;
  logic                   pend_full_q;

  // response register
  logic                   out_valid_q;
  cdq_pkg::rsp_t          out_q;

  // ram port
  logic                         ram_we, ram_re;
  logic [cdq_pkg::AW-1:0]       ram_waddr, ram_raddr;
  logic [cdq_pkg::DW-1:0]       ram_rdata;

  logic       accept;
  logic       is_empty, is_full, is_push, at_front;
  logic [1:0] status_d;
  logic       pop_ok_d;

  // take a new request only with nothing in flight and the response slot
  // free or draining this cycle
  assign req_ready_o = !pend_q && (!out_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == cdq_pkg::DEPTH_CNT);
  assign is_push  = (req_i.action == cdq_pkg::ACT_PUSH_FRONT) ||
                    (req_i.action == cdq_pkg::ACT_PUSH_BACK);
  assign at_front = (req_i.action == cdq_pkg::ACT_PUSH_FRONT) ||
                    (req_i.action == cdq_pkg::ACT_POP_FRONT);

  // all pointer updates happen at accept; the ram only supplies pop data
  always_comb begin
    front_d   = front_q;
    rear_d    = rear_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = front_q;
    ram_raddr = front_q;
    status_d  = cdq_pkg::ST_OK;
    pop_ok_d  = 1'b0;
    if (accept) begin
      if (is_push) begin
        if (is_full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + cdq_pkg::CW'(1);
          if (is_empty) begin
            // first word always lands in entry zero
            front_d   = '0;
            rear_d    = '0;
            ram_waddr = '0;
          end else if (at_front) begin
            front_d   = cdq_pkg::ring_down(front_q);
            ram_waddr = front_d;
          end else begin
            rear_d    = cdq_pkg::ring_up(rear_q);
            ram_waddr = rear_d;
          end
        end
      end else begin
        if (is_empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          ram_re   = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - cdq_pkg::CW'(1);
          if (at_front) begin
            ram_raddr = front_q;
            // the last word leaves the pointers where they are
            if (count_q != cdq_pkg::CW'(1)) begin
              front_d = cdq_pkg::ring_up(front_q);
            end
          end else begin
            ram_raddr = rear_q;
            if (count_q != cdq_pkg::CW'(1)) begin
              rear_d = cdq_pkg::ring_down(rear_q);
            end
          end
        end
      end
    end
  end

  cdq_ram #(
    .WIDTH (cdq_pkg::DW),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      pend_q  <= accept;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_pop_q    <= pop_ok_d;
      pend_status_q <= status_d;
      pend_empty_q  <= (count_d == '0);
      pend_full_q   <= (count_d == cdq_pkg::DEPTH_CNT);
    end
    if (pend_q) begin
      out_q.data       <= pend_pop_q ? $signed(ram_rdata) : cdq_pkg::NO_DATA;
      out_q.status     <= pend_status_q;
      out_q.empty_flag <= pend_empty_q;
      out_q.full_flag  <= pend_full_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

>>> hw/rtl/cdq_checker.sv
module cdq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input cdq_pkg::req_t req_i,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input cdq_pkg::rsp_t rsp_o
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped or changed under stall");

  // every accepted request drops ready, then raises a response; none overlap
  a_rsp_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o ##1 rsp_valid_o)
    else $error("response missing after request");

  // a rejected push reports a full deque and no data
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == cdq_pkg::ST_FULL |->
      rsp_o.full_flag && !rsp_o.empty_flag && rsp_o.data == cdq_pkg::NO_DATA)
    else $error("full rejection inconsistent");

  // a rejected pop reports an empty deque and no data
  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == cdq_pkg::ST_EMPTY |->
      rsp_o.empty_flag && !rsp_o.full_flag && rsp_o.data == cdq_pkg::NO_DATA)
    else $error("empty rejection inconsistent");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);
